/* hw/rtl/adc_sequencer_register_block_unit_defines.svh */
// Assertion macros used by the ADC sequencer register block RTL.
`ifndef ADC_SEQUENCER_REGISTER_BLOCK_UNIT_DEFINES_SVH
`define ADC_SEQUENCER_REGISTER_BLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ASRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/asrb_pkg.sv */
// Types, word map, timing tables and helpers of the ADC sequencer register block.
`default_nettype none
package asrb_pkg;

   localparam int CHANNELS_DEF  = 19;
   localparam int REG_WORDS_DEF = 20;
   localparam int IDX_W         = 5;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_SAMPLE = 2'd3
   } kind_type;

   localparam logic [IDX_W-1:0] WORD_ISR   = 5'd0;
   localparam logic [IDX_W-1:0] WORD_IER   = 5'd1;
   localparam logic [IDX_W-1:0] WORD_CR    = 5'd2;
   localparam logic [IDX_W-1:0] WORD_CFGR  = 5'd3;
   localparam logic [IDX_W-1:0] WORD_SMPR1 = 5'd5;
   localparam logic [IDX_W-1:0] WORD_SMPR2 = 5'd6;
   localparam logic [IDX_W-1:0] WORD_SQR1  = 5'd12;
   localparam logic [IDX_W-1:0] WORD_SQR2  = 5'd13;
   localparam logic [IDX_W-1:0] WORD_SQR3  = 5'd14;
   localparam logic [IDX_W-1:0] WORD_SQR4  = 5'd15;
   localparam logic [IDX_W-1:0] WORD_DR    = 5'd16;

   localparam int ISR_ADRDY   = 0;
   localparam int ISR_EOC     = 2;
   localparam int ISR_EOS     = 3;
   localparam int CR_ADEN     = 0;
   localparam int CR_ADDIS    = 1;
   localparam int CR_ADSTART  = 2;
   localparam int CR_ADCAL    = 31;
   localparam int CFGR_CONT   = 13;
   localparam int CFGR_RES_LO = 3;

   localparam logic [11:0] LEVEL_MAX = 12'hfff;

   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  idx;
      logic [31:0]       data;
      logic [3:0]        be;
      logic [4:0]        ch;
      logic [15:0]       sv;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        conversion_done;
      logic [4:0]  done_channel;
      logic [11:0] done_value;
      logic        end_of_sequence;
      logic        irq_pulse;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [31:0]      data;
   } mem_wr_type;

   function automatic logic [10:0] sample_ticks(input logic [2:0] sel);
      logic [10:0] t;
      case (sel)
         3'd0:    t = 11'd5;
         3'd1:    t = 11'd13;
         3'd2:    t = 11'd25;
         3'd3:    t = 11'd49;
         3'd4:    t = 11'd95;
         3'd5:    t = 11'd185;
         3'd6:    t = 11'd495;
         default: t = 11'd1281;
      endcase
      return t;
   endfunction

   function automatic logic [10:0] convert_ticks(input logic [1:0] res);
      logic [10:0] t;
      case (res)
         2'd0:    t = 11'd25;
         2'd1:    t = 11'd21;
         2'd2:    t = 11'd17;
         default: t = 11'd13;
      endcase
      return t;
   endfunction

   // Raw channel field of a rank in SQR1..SQR4.
   function automatic logic [4:0] seq_chan(input logic [3:0] rank, input logic [31:0] sqr1,
                                           input logic [31:0] sqr2, input logic [31:0] sqr3,
                                           input logic [31:0] sqr4);
      logic [31:0] w;
      logic [4:0]  sh;
      if (rank >= 4'd14) begin
         w  = sqr4;
         sh = (rank == 4'd14) ? 5'd0 : 5'd6;
      end else if (rank >= 4'd9) begin
         w  = sqr3;
         sh = 5'(6 * (int'(rank) - 9));
      end else if (rank >= 4'd4) begin
         w  = sqr2;
         sh = 5'(6 * (int'(rank) - 4));
      end else begin
         w  = sqr1;
         sh = 5'(6 + 6 * int'(rank));
      end
      return w[sh +: 5];
   endfunction

   // Sample plus conversion half-cycles for a channel.
   function automatic logic [10:0] rank_ticks(input logic [4:0] ch, input logic [31:0] smpr1,
                                              input logic [31:0] smpr2, input logic [31:0] cfgr);
      logic [66:0] w;
      logic [5:0]  sh;
      logic [2:0]  sel;
      if (ch <= 5'd9) begin
         w  = {35'b0, smpr1};
         sh = 6'(3 * int'(ch));
      end else begin
         w  = {35'b0, smpr2};
         sh = 6'(3 * (int'(ch) - 10));
      end
      sel = w[sh +: 3];
      return sample_ticks(sel) + convert_ticks(cfgr[CFGR_RES_LO +: 2]);
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/asrb_word_mem.sv */
// General register words: one write port, one registered read port, valid bits.
`default_nettype none
module asrb_word_mem #(
   parameter int REG_WORDS = asrb_pkg::REG_WORDS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [asrb_pkg::IDX_W-1:0]   rd_idx,
   input  wire asrb_pkg::mem_wr_type         wr,
   output logic [31:0]                       rd_data
);
   import asrb_pkg::*;

   localparam int AW = $clog2(REG_WORDS);

   logic [31:0]          mem_ff [REG_WORDS];
   logic [REG_WORDS-1:0] vld_ff;
   logic [31:0]          rd_data_ff;
   logic                 rd_vld_ff;
   logic                 fwd_hit_ff;
   logic [31:0]          fwd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;

   assign rd_addr = AW'(rd_idx);
   assign wr_addr = AW'(wr.idx);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff  <= vld_ff[rd_addr];
            fwd_hit_ff <= wr.en && (wr.idx == rd_idx);
         end
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : 32'd0);

endmodule
`default_nettype wire

/* hw/rtl/asrb_regs.sv */
// Control registers, channel levels and conversion sequencer, updated once per request.
`default_nettype none
`include "adc_sequencer_register_block_unit_defines.svh"
module asrb_regs #(
   parameter int CHANNELS  = asrb_pkg::CHANNELS_DEF,
   parameter int REG_WORDS = asrb_pkg::REG_WORDS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire asrb_pkg::req_type    req,
   input  wire logic [31:0]          gen_rd,
   output asrb_pkg::rsp_type         rsp,
   output asrb_pkg::mem_wr_type      mem_wr
);
   import asrb_pkg::*;

   localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic        adrdy_ff, adrdy_in;
   logic        eoc_ff, eoc_in;
   logic        eos_ff, eos_in;
   logic [31:0] ier_ff, ier_in;
   logic [31:0] cr_ff, cr_in;
   logic [31:0] cfgr_ff, cfgr_in;
   logic [31:0] smpr1_ff, smpr1_in;
   logic [31:0] smpr2_ff, smpr2_in;
   logic [31:0] sqr1_ff, sqr1_in;
   logic [31:0] sqr2_ff, sqr2_in;
   logic [31:0] sqr3_ff, sqr3_in;
   logic [31:0] sqr4_ff, sqr4_in;
   logic [11:0] dr_ff, dr_in;
   logic [3:0]  rank_ff, rank_in;
   logic [10:0] ticks_ff, ticks_in;
   logic        conv_ff, conv_in;
   logic [11:0] level_ff [CHANNELS];

   logic              lvl_we;
   logic [CH_AW-1:0]  lvl_idx;
   logic [11:0]       lvl_val;

   logic              in_range;
   logic [31:0]       mask;
   logic [31:0]       cur;
   logic [31:0]       merged;
   logic [31:0]       dmask;
   logic [31:0]       ctl;
   logic [4:0]        raw_cur, raw_next, raw_r0;
   logic [4:0]        ch_cur, ch_next, ch_r0;
   logic [10:0]       ticks_next, ticks_r0, ticks_dec;
   logic              last;
   logic [3:0]        rank_next;
   logic [11:0]       val_cur;

   always_comb begin
      in_range = int'(req.idx) < REG_WORDS;
      mask     = {{8{req.be[3]}}, {8{req.be[2]}}, {8{req.be[1]}}, {8{req.be[0]}}};
      dmask    = req.data & mask;

      case (req.idx)
         WORD_ISR:   cur = {28'd0, eos_ff, eoc_ff, 1'b0, adrdy_ff};
         WORD_IER:   cur = ier_ff;
         WORD_CR:    cur = cr_ff;
         WORD_CFGR:  cur = cfgr_ff;
         WORD_SMPR1: cur = smpr1_ff;
         WORD_SMPR2: cur = smpr2_ff;
         WORD_SQR1:  cur = sqr1_ff;
         WORD_SQR2:  cur = sqr2_ff;
         WORD_SQR3:  cur = sqr3_ff;
         WORD_SQR4:  cur = sqr4_ff;
         WORD_DR:    cur = {20'd0, dr_ff};
         default:    cur = gen_rd;
      endcase
      merged = (cur & ~mask) | dmask;

      raw_cur   = seq_chan(rank_ff, sqr1_ff, sqr2_ff, sqr3_ff, sqr4_ff);
      ch_cur    = (int'(raw_cur) < CHANNELS) ? raw_cur : 5'd0;
      val_cur   = level_ff[CH_AW'(ch_cur)];
      last      = rank_ff >= sqr1_ff[3:0];
      rank_next = last ? 4'd0 : rank_ff + 4'd1;

      raw_next   = seq_chan(rank_next, sqr1_ff, sqr2_ff, sqr3_ff, sqr4_ff);
      ch_next    = (int'(raw_next) < CHANNELS) ? raw_next : 5'd0;
      ticks_next = rank_ticks(ch_next, smpr1_ff, smpr2_ff, cfgr_ff);

      raw_r0   = seq_chan(4'd0, sqr1_ff, sqr2_ff, sqr3_ff, sqr4_ff);
      ch_r0    = (int'(raw_r0) < CHANNELS) ? raw_r0 : 5'd0;
      ticks_r0 = rank_ticks(ch_r0, smpr1_ff, smpr2_ff, cfgr_ff);

      ticks_dec = (ticks_ff != 11'd0) ? ticks_ff - 11'd1 : 11'd0;

      adrdy_in = adrdy_ff;
      eoc_in   = eoc_ff;
      eos_in   = eos_ff;
      ier_in   = ier_ff;
      cr_in    = cr_ff;
      cfgr_in  = cfgr_ff;
      smpr1_in = smpr1_ff;
      smpr2_in = smpr2_ff;
      sqr1_in  = sqr1_ff;
      sqr2_in  = sqr2_ff;
      sqr3_in  = sqr3_ff;
      sqr4_in  = sqr4_ff;
      dr_in    = dr_ff;
      rank_in  = rank_ff;
      ticks_in = ticks_ff;
      conv_in  = conv_ff;
      ctl      = merged;
      lvl_we   = 1'b0;
      lvl_idx  = CH_AW'(req.ch);
      lvl_val  = (req.sv > 16'(LEVEL_MAX)) ? LEVEL_MAX : req.sv[11:0];
      rsp      = '0;
      mem_wr   = '0;

      case (req.kind)
         KIND_READ: begin
            if (in_range) begin
               rsp.read_data = cur;
               if (req.idx == WORD_DR) begin
                  eoc_in = 1'b0;
                  eos_in = 1'b0;
               end
            end
         end
         KIND_WRITE: begin
            if (in_range) begin
               case (req.idx)
                  WORD_ISR: begin
                     adrdy_in = adrdy_ff & ~dmask[ISR_ADRDY];
                     eoc_in   = eoc_ff & ~dmask[ISR_EOC];
                     eos_in   = eos_ff & ~dmask[ISR_EOS];
                  end
                  WORD_DR: begin
                  end
                  WORD_CR: begin
                     ctl[CR_ADCAL] = 1'b0;
                     if (ctl[CR_ADDIS]) begin
                        ctl[CR_ADDIS]   = 1'b0;
                        ctl[CR_ADEN]    = 1'b0;
                        ctl[CR_ADSTART] = 1'b0;
                        adrdy_in        = 1'b0;
                        conv_in         = 1'b0;
                        ticks_in        = 11'd0;
                     end
                     if (ctl[CR_ADEN]) begin
                        adrdy_in = 1'b1;
                     end
                     cr_in = ctl;
                     if (ctl[CR_ADSTART]) begin
                        rank_in  = 4'd0;
                        ticks_in = ticks_r0;
                        conv_in  = 1'b1;
                     end
                  end
                  WORD_IER:   ier_in   = merged;
                  WORD_CFGR:  cfgr_in  = merged;
                  WORD_SMPR1: smpr1_in = merged;
                  WORD_SMPR2: smpr2_in = merged;
                  WORD_SQR1:  sqr1_in  = merged;
                  WORD_SQR2:  sqr2_in  = merged;
                  WORD_SQR3:  sqr3_in  = merged;
                  WORD_SQR4:  sqr4_in  = merged;
                  default: begin
                     mem_wr.en   = step;
                     mem_wr.idx  = req.idx;
                     mem_wr.data = merged;
                  end
               endcase
            end
         end
         KIND_TICK: begin
            if (conv_ff) begin
               if (ticks_dec != 11'd0) begin
                  ticks_in = ticks_dec;
               end else begin
                  dr_in  = val_cur;
                  eoc_in = 1'b1;
                  if (last) begin
                     eos_in = 1'b1;
                  end
                  rsp.conversion_done = 1'b1;
                  rsp.done_channel    = ch_cur;
                  rsp.done_value      = val_cur;
                  rsp.end_of_sequence = last;
                  rsp.irq_pulse       = ier_ff[ISR_EOC] | ier_ff[ISR_EOS];
                  rank_in             = rank_next;
                  if ((!last || cfgr_ff[CFGR_CONT]) && cr_ff[CR_ADSTART]) begin
                     ticks_in = ticks_next;
                     conv_in  = 1'b1;
                  end else begin
                     cr_in[CR_ADSTART] = 1'b0;
                     ticks_in          = 11'd0;
                     conv_in           = 1'b0;
                  end
               end
            end
         end
         KIND_SAMPLE: begin
            lvl_we = int'(req.ch) < CHANNELS;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adrdy_ff <= 1'b0;
         eoc_ff   <= 1'b0;
         eos_ff   <= 1'b0;
         ier_ff   <= '0;
         cr_ff    <= '0;
         cfgr_ff  <= '0;
         smpr1_ff <= '0;
         smpr2_ff <= '0;
         sqr1_ff  <= '0;
         sqr2_ff  <= '0;
         sqr3_ff  <= '0;
         sqr4_ff  <= '0;
         dr_ff    <= '0;
         rank_ff  <= '0;
         ticks_ff <= '0;
         conv_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i] <= '0;
         end
      end else if (step) begin
         adrdy_ff <= adrdy_in;
         eoc_ff   <= eoc_in;
         eos_ff   <= eos_in;
         ier_ff   <= ier_in;
         cr_ff    <= cr_in;
         cfgr_ff  <= cfgr_in;
         smpr1_ff <= smpr1_in;
         smpr2_ff <= smpr2_in;
         sqr1_ff  <= sqr1_in;
         sqr2_ff  <= sqr2_in;
         sqr3_ff  <= sqr3_in;
         sqr4_ff  <= sqr4_in;
         dr_ff    <= dr_in;
         rank_ff  <= rank_in;
         ticks_ff <= ticks_in;
         conv_ff  <= conv_in;
         if (lvl_we) begin
            level_ff[lvl_idx] <= lvl_val;
         end
      end
   end

   `ASRB_ASSERT_NOW(a_done_on_tick, clock, reset, step && rsp.conversion_done, req.kind == KIND_TICK && conv_ff, "conversion done outside a running tick")
   `ASRB_ASSERT_NOW(a_ticks_track_conv, clock, reset, 1'b1, conv_ff == (ticks_ff != 11'd0), "tick count out of step with conversion state")
   `ASRB_ASSERT_NEXT(a_eos_wraps_rank, clock, reset, step && rsp.end_of_sequence, eos_ff && rank_ff == 4'd0, "end of sequence without EOS and rank wrap")

endmodule
`default_nettype wire

/* hw/rtl/adc_sequencer_register_block_unit.sv */
// ADC regular-sequence register block
//
// Request channel (req_*): kind 0 bus read, 1 bus write (byte lanes in
// req_byte_enable), 2 half ADC clock tick, 3 set channel analog level.
// Response channel (rsp_*): exactly one response per request, in order:
// read data for a bus read, conversion status on the tick that finishes one.
// Both channels use valid/ready.
// An accepted request is held in the request register and then moves to the
// response register, which drives rsp_valid. Throughput: one request per
// cycle unless a stalled response fills both registers; all state is updated
// in the single cycle a request moves from the request register to the
// response register. General register words live in a small RAM whose read
// is issued at request accept, with write forwarding.
// Reset clears all registers, channel levels and the sequencer; the block
// takes requests in the first cycle after reset.
// A stalled response holds the response register and then the request
// register; req_ready drops only when both are full and rsp_ready is low.
`default_nettype none
module adc_sequencer_register_block_unit #(
   parameter int CHANNELS  = asrb_pkg::CHANNELS_DEF,
   parameter int REG_WORDS = asrb_pkg::REG_WORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [6:0]  req_offset,
   input  wire logic [31:0] req_write_data,
   input  wire logic [3:0]  req_byte_enable,
   input  wire logic [4:0]  req_channel,
   input  wire logic [15:0] req_sample_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_conversion_done,
   output logic [4:0]       rsp_done_channel,
   output logic [11:0]      rsp_done_value,
   output logic             rsp_end_of_sequence,
   output logic             rsp_irq_pulse
);
   import asrb_pkg::*;

   logic       in_vld_ff, in_vld_in;
   req_type    in_req_ff;
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_rsp_ff;
   logic       step;
   logic       accept;
   req_type    req_new;
   rsp_type    rsp_new;
   mem_wr_type mem_wr;
   logic [31:0] gen_rd;

   assign step      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || step;
   assign accept    = req_valid && req_ready;

   always_comb begin
      req_new.kind = kind_type'(req_kind);
      req_new.idx  = req_offset[6:2];
      req_new.data = req_write_data;
      req_new.be   = req_byte_enable;
      req_new.ch   = req_channel;
      req_new.sv   = req_sample_value;
      in_vld_in    = accept ? 1'b1 : (step ? 1'b0 : in_vld_ff);
      out_vld_in   = step ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_new;
      end
      if (step) begin
         out_rsp_ff <= rsp_new;
      end
   end

   asrb_word_mem #(
      .REG_WORDS(REG_WORDS)
   ) u_word_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (req_offset[6:2]),
      .wr      (mem_wr),
      .rd_data (gen_rd)
   );

   asrb_regs #(
      .CHANNELS (CHANNELS),
      .REG_WORDS(REG_WORDS)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (in_req_ff),
      .gen_rd (gen_rd),
      .rsp    (rsp_new),
      .mem_wr (mem_wr)
   );

   assign rsp_valid           = out_vld_ff;
   assign rsp_read_data       = out_rsp_ff.read_data;
   assign rsp_conversion_done = out_rsp_ff.conversion_done;
   assign rsp_done_channel    = out_rsp_ff.done_channel;
   assign rsp_done_value      = out_rsp_ff.done_value;
   assign rsp_end_of_sequence = out_rsp_ff.end_of_sequence;
   assign rsp_irq_pulse       = out_rsp_ff.irq_pulse;

endmodule
`default_nettype wire

/* test/adc_sequencer_register_block_unit_tb.sv */
// Testbench for the ADC sequencer register block: scoreboard against an in-bench register model.
`timescale 1ns / 100ps
module adc_sequencer_register_block_unit_tb;
   import asrb_pkg::*;

   localparam int NWORDS      = REG_WORDS_DEF;
   localparam int NCHAN       = CHANNELS_DEF;
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [6:0]  req_offset;
   logic [31:0] req_write_data;
   logic [3:0]  req_byte_enable;
   logic [4:0]  req_channel;
   logic [15:0] req_sample_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_conversion_done;
   logic [4:0]  rsp_done_channel;
   logic [11:0] rsp_done_value;
   logic        rsp_end_of_sequence;
   logic        rsp_irq_pulse;

   adc_sequencer_register_block_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_offset          (req_offset),
      .req_write_data      (req_write_data),
      .req_byte_enable     (req_byte_enable),
      .req_channel         (req_channel),
      .req_sample_value    (req_sample_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_conversion_done (rsp_conversion_done),
      .rsp_done_channel    (rsp_done_channel),
      .rsp_done_value      (rsp_done_value),
      .rsp_end_of_sequence (rsp_end_of_sequence),
      .rsp_irq_pulse       (rsp_irq_pulse)
   );

   // register model state
   logic [31:0] model_regs [NWORDS];
   logic [11:0] model_levels [NCHAN];
   logic [3:0]  model_rank;
   logic [10:0] model_ticks;
   logic        model_busy;

   rsp_type expected_rsps [$];
   int      mismatches;
   int      rsp_count;
   int      requests_sent;
   logic    no_gaps;
   int      holds_asked;
   int      holds_done;
   int      hold_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [4:0] rank_source(input logic [3:0] rank);
      logic [31:0] w;
      int          sh;
      logic [4:0]  ch;
      if (rank >= 4'd14) begin
         w  = model_regs[WORD_SQR4];
         sh = 6 * (int'(rank) - 14);
      end else if (rank >= 4'd9) begin
         w  = model_regs[WORD_SQR3];
         sh = 6 * (int'(rank) - 9);
      end else if (rank >= 4'd4) begin
         w  = model_regs[WORD_SQR2];
         sh = 6 * (int'(rank) - 4);
      end else begin
         w  = model_regs[WORD_SQR1];
         sh = 6 + 6 * int'(rank);
      end
      ch = 5'(w >> sh);
      return (int'(ch) < NCHAN) ? ch : 5'd0;
   endfunction

   function automatic logic [10:0] rank_duration(input logic [3:0] rank);
      logic [4:0]  ch;
      logic [63:0] w;
      logic [10:0] samp;
      logic [10:0] conv;
      ch = rank_source(rank);
      if (ch <= 5'd9) w = {32'd0, model_regs[WORD_SMPR1]} >> (3 * int'(ch));
      else w = {32'd0, model_regs[WORD_SMPR2]} >> (3 * (int'(ch) - 10));
      case (w[2:0])
         3'd0:    samp = 11'd5;
         3'd1:    samp = 11'd13;
         3'd2:    samp = 11'd25;
         3'd3:    samp = 11'd49;
         3'd4:    samp = 11'd95;
         3'd5:    samp = 11'd185;
         3'd6:    samp = 11'd495;
         default: samp = 11'd1281;
      endcase
      case (model_regs[WORD_CFGR][CFGR_RES_LO +: 2])
         2'd0:    conv = 11'd25;
         2'd1:    conv = 11'd21;
         2'd2:    conv = 11'd17;
         default: conv = 11'd13;
      endcase
      return samp + conv;
   endfunction

   function automatic rsp_type predict_rsp(input kind_type k, input logic [6:0] off,
                                           input logic [31:0] wd, input logic [3:0] lanes,
                                           input logic [4:0] ch, input logic [15:0] sv);
      rsp_type     r;
      logic [4:0]  idx;
      logic [31:0] mask;
      logic [31:0] cr;
      logic [4:0]  src;
      logic        last;
      r   = '0;
      idx = off[6:2];
      for (int i = 0; i < 4; i++) mask[8*i +: 8] = {8{lanes[i]}};
      case (k)
         KIND_READ: if (int'(idx) < NWORDS) begin
            r.read_data = model_regs[idx];
            if (idx == WORD_DR) begin
               model_regs[WORD_ISR][ISR_EOC] = 1'b0;
               model_regs[WORD_ISR][ISR_EOS] = 1'b0;
            end
         end
         KIND_WRITE: if (int'(idx) < NWORDS) begin
            if (idx == WORD_ISR) begin
               model_regs[WORD_ISR] &= ~(wd & mask);
            end else if (idx == WORD_CR) begin
               cr = (model_regs[WORD_CR] & ~mask) | (wd & mask);
               cr[CR_ADCAL] = 1'b0;
               if (cr[CR_ADDIS]) begin
                  cr[CR_ADDIS]   = 1'b0;
                  cr[CR_ADEN]    = 1'b0;
                  cr[CR_ADSTART] = 1'b0;
                  model_regs[WORD_ISR][ISR_ADRDY] = 1'b0;
                  model_busy  = 1'b0;
                  model_ticks = '0;
               end
               if (cr[CR_ADEN]) model_regs[WORD_ISR][ISR_ADRDY] = 1'b1;
               model_regs[WORD_CR] = cr;
               if (cr[CR_ADSTART]) begin
                  model_rank  = 4'd0;
                  model_ticks = rank_duration(4'd0);
                  model_busy  = 1'b1;
               end
            end else if (idx != WORD_DR) begin
               model_regs[idx] = (model_regs[idx] & ~mask) | (wd & mask);
            end
         end
         KIND_TICK: if (model_busy) begin
            if (model_ticks != 0) model_ticks--;
            if (model_ticks == 0) begin
               src  = rank_source(model_rank);
               last = model_rank >= model_regs[WORD_SQR1][3:0];
               model_regs[WORD_DR] = {20'd0, model_levels[src]};
               model_regs[WORD_ISR][ISR_EOC] = 1'b1;
               if (last) model_regs[WORD_ISR][ISR_EOS] = 1'b1;
               r.conversion_done = 1'b1;
               r.done_channel    = src;
               r.done_value      = model_levels[src];
               r.end_of_sequence = last;
               r.irq_pulse = model_regs[WORD_IER][ISR_EOC] | model_regs[WORD_IER][ISR_EOS];
               model_rank = last ? 4'd0 : model_rank + 4'd1;
               if ((!last || model_regs[WORD_CFGR][CFGR_CONT])
                   && model_regs[WORD_CR][CR_ADSTART]) begin
                  model_ticks = rank_duration(model_rank);
               end else begin
                  model_regs[WORD_CR][CR_ADSTART] = 1'b0;
                  model_busy  = 1'b0;
                  model_ticks = '0;
               end
            end
         end
         KIND_SAMPLE: if (int'(ch) < NCHAN) begin
            model_levels[ch] = (sv > 16'h0fff) ? LEVEL_MAX : sv[11:0];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // request sender: accept is seen at the falling edge before the accepting rising edge
   task automatic send_req(input kind_type k, input logic [6:0] off, input logic [31:0] wd,
                           input logic [3:0] lanes, input logic [4:0] ch,
                           input logic [15:0] sv);
      while (!no_gaps && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= k;
      req_offset       <= off;
      req_write_data   <= wd;
      req_byte_enable  <= lanes;
      req_channel      <= ch;
      req_sample_value <= sv;
      do @(negedge clock); while (!req_ready);
      expected_rsps.insert(expected_rsps.size(), predict_rsp(k, off, wd, lanes, ch, sv));
      requests_sent++;
      @(posedge clock);
   endtask

   task automatic bus_read(input logic [4:0] idx);
      send_req(KIND_READ, {idx, 2'($urandom)}, $urandom, 4'($urandom), 5'($urandom),
               16'($urandom));
   endtask

   task automatic bus_write(input logic [4:0] idx, input logic [31:0] data,
                            input logic [3:0] lanes);
      send_req(KIND_WRITE, {idx, 2'($urandom)}, data, lanes, 5'($urandom), 16'($urandom));
   endtask

   task automatic clock_ticks(input int n);
      repeat (n) send_req(KIND_TICK, 7'($urandom), $urandom, 4'($urandom), 5'($urandom),
                          16'($urandom));
   endtask

   task automatic set_level(input logic [4:0] ch, input logic [15:0] sv);
      send_req(KIND_SAMPLE, 7'($urandom), $urandom, 4'($urandom), ch, sv);
   endtask

   task automatic run_episode();
      logic [31:0] w;
      int          pick;
      bus_write(WORD_CFGR, $urandom, 4'hf);
      for (int s = 0; s < 2; s++) begin
         w = '0;
         for (int f = 0; f < 10; f++)
            w[3*f +: 3] = ($urandom_range(99) < 90) ? 3'($urandom_range(2))
                                                   : 3'($urandom_range(5, 3));
         w[31:30] = 2'($urandom);
         bus_write(s == 0 ? WORD_SMPR1 : WORD_SMPR2, w, 4'hf);
      end
      for (int q = int'(WORD_SQR1); q <= int'(WORD_SQR4); q++) bus_write(5'(q), $urandom, 4'hf);
      bus_write(WORD_IER, $urandom, 4'($urandom));
      repeat (3) set_level(5'($urandom), 16'($urandom));
      w = $urandom;
      w[CR_ADDIS]   = 1'b0;
      w[CR_ADSTART] = 1'b1;
      bus_write(WORD_CR, w, 4'hf);
      repeat ($urandom_range(150, 30)) begin
         pick = $urandom_range(99);
         if (pick < 68) begin
            clock_ticks(1);
         end else if (pick < 74) begin
            bus_read(WORD_DR);
         end else if (pick < 80) begin
            bus_read(5'($urandom_range(NWORDS - 1)));
         end else if (pick < 87) begin
            set_level(5'($urandom), $urandom_range(1) ? 16'($urandom)
                                                      : 16'($urandom_range(4095)));
         end else if (pick < 91) begin
            bus_write(WORD_ISR, $urandom, 4'($urandom));
         end else if (pick < 93) begin
            bus_write(WORD_IER, $urandom, 4'($urandom));
         end else if (pick < 95) begin
            w = $urandom;
            w[CR_ADDIS] = ($urandom_range(3) == 0);
            bus_write(WORD_CR, w, 4'($urandom));
         end else begin
            send_req(kind_type'($urandom_range(3)), 7'($urandom), $urandom, 4'($urandom),
                     5'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic test_register_access();
      send_req(KIND_READ, 7'h7f, 32'h0, 4'hf, 5'd0, 16'd0);
      bus_write(5'd20, 32'hffff_ffff, 4'hf);
      bus_write(5'd31, 32'hffff_ffff, 4'hf);
      bus_write(WORD_IER, 32'hffff_ffff, 4'b0101);
      bus_read(WORD_IER);
      bus_write(WORD_DR, 32'h1234_5678, 4'hf);
      bus_read(WORD_DR);
      bus_write(WORD_CR, (32'd1 << CR_ADCAL) | (32'd1 << CR_ADEN), 4'hf);
      bus_read(WORD_CR);
      bus_read(WORD_ISR);
      bus_write(WORD_ISR, 32'hffff_ffff, 4'hf);
      bus_read(WORD_ISR);
      set_level(5'd0, 16'hffff);
      set_level(5'd18, 16'h0abc);
      set_level(5'd19, 16'h0123);
      set_level(5'd31, 16'h0000);
   endtask

   task automatic test_short_sequence();
      bus_write(WORD_CFGR, 32'd3 << CFGR_RES_LO, 4'hf);
      bus_write(WORD_SMPR1, 32'h0, 4'hf);
      bus_write(WORD_SMPR2, 32'h0, 4'hf);
      // two ranks: out-of-range channel 25 (falls back to 0), then channel 18
      bus_write(WORD_SQR1, 32'd1 | (32'd25 << 6) | (32'd18 << 12), 4'hf);
      bus_write(WORD_IER, 32'd1 << ISR_EOS, 4'hf);
      clock_ticks(1);
      bus_write(WORD_CR, (32'd1 << CR_ADEN) | (32'd1 << CR_ADSTART), 4'hf);
      clock_ticks(10);
      // restart while converting, enable bit cleared
      bus_write(WORD_CR, 32'd1 << CR_ADSTART, 4'h1);
      clock_ticks(40);
      bus_read(WORD_ISR);
      bus_read(WORD_DR);
      bus_read(WORD_ISR);
      bus_write(WORD_CR, (32'd1 << CR_ADEN) | (32'd1 << CR_ADSTART), 4'hf);
      clock_ticks(5);
      bus_write(WORD_CR, (32'd1 << CR_ADDIS) | (32'd1 << CR_ADEN), 4'hf);
      clock_ticks(20);
      bus_read(WORD_ISR);
      bus_read(WORD_CR);
   endtask

   task automatic test_full_sequence();
      bus_write(WORD_CFGR, (32'd3 << CFGR_RES_LO) | (32'd1 << CFGR_CONT), 4'hf);
      bus_write(WORD_SMPR1, 32'h0, 4'hf);
      bus_write(WORD_SMPR2, 32'h0, 4'hf);
      bus_write(WORD_SQR1, $urandom | 32'hf, 4'hf);
      bus_write(WORD_SQR2, $urandom, 4'hf);
      bus_write(WORD_SQR3, $urandom, 4'hf);
      bus_write(WORD_SQR4, $urandom, 4'hf);
      bus_write(WORD_CR, (32'd1 << CR_ADEN) | (32'd1 << CR_ADSTART), 4'hf);
      clock_ticks(18 * 17 + 4);
      bus_write(WORD_CR, 32'd1 << CR_ADDIS, 4'hf);
      bus_read(WORD_DR);
   endtask

   task automatic test_longest_conversion();
      bus_write(WORD_CFGR, 32'h0, 4'hf);
      bus_write(WORD_SMPR2, 32'hffff_ffff, 4'hf);
      bus_write(WORD_SQR1, 32'd18 << 6, 4'hf);
      bus_write(WORD_SQR4, 32'h0, 4'hf);
      bus_write(WORD_CR, (32'd1 << CR_ADEN) | (32'd1 << CR_ADSTART), 4'hf);
      clock_ticks(1281 + 25 + 2);
      bus_read(WORD_DR);
   endtask

   task automatic test_response_hold();
      holds_asked <= holds_asked + 1;
      run_episode();
   endtask

   task automatic test_steady_stream();
      no_gaps <= 1'b1;
      run_episode();
      no_gaps <= 1'b0;
   endtask

   task automatic test_random_sequences();
      int stop_at;
      stop_at = requests_sent + 400;
      while (requests_sent < stop_at) run_episode();
   endtask

   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         rsp_ready <= 1'b0;
         if (hold_count == HOLD_CYCLES - 1) begin
            hold_count <= 0;
            holds_done <= holds_asked;
         end else begin
            hold_count <= hold_count + 1;
         end
      end else begin
         rsp_ready <= no_gaps || ($urandom_range(99) >= 9);
      end
   end

   task automatic flag_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
      mismatches++;
      if (mismatches <= 10)
         $display("response %0d %s: expected %h, got %h", rsp_count, name, want, seen);
   endtask

   always @(negedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response %0d with no request outstanding", rsp_count);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_read_data !== want.read_data)
               flag_field("read_data", want.read_data, rsp_read_data);
            if (rsp_conversion_done !== want.conversion_done)
               flag_field("conversion_done", want.conversion_done, rsp_conversion_done);
            if (rsp_done_channel !== want.done_channel)
               flag_field("done_channel", want.done_channel, rsp_done_channel);
            if (rsp_done_value !== want.done_value)
               flag_field("done_value", want.done_value, rsp_done_value);
            if (rsp_end_of_sequence !== want.end_of_sequence)
               flag_field("end_of_sequence", want.end_of_sequence, rsp_end_of_sequence);
            if (rsp_irq_pulse !== want.irq_pulse)
               flag_field("irq_pulse", want.irq_pulse, rsp_irq_pulse);
         end
         rsp_count++;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = '0;
      req_offset       = '0;
      req_write_data   = '0;
      req_byte_enable  = '0;
      req_channel      = '0;
      req_sample_value = '0;
      no_gaps          = 1'b0;
      for (int i = 0; i < NWORDS; i++) model_regs[i] = '0;
      for (int i = 0; i < NCHAN; i++) model_levels[i] = '0;
      model_rank  = '0;
      model_ticks = '0;
      model_busy  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_short_sequence();
      test_full_sequence();
      test_longest_conversion();
      test_response_hold();
      test_steady_stream();
      test_random_sequences();

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
